// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, off while rst_ni is low.
`define PSBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("psbm assertion failed");

// Checked on every rising edge of clk_i, also during reset.
`define PSBM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("psbm assertion failed");

`endif

// ===== rtl/psbm_pkg.sv =====
`default_nettype none

package psbm_pkg;

  // Field widths
  localparam int PORT_W = 4;
  localparam int OCC_W  = 13;
  localparam int CNT_W  = 32;
  localparam int LIM_W  = 12;
  localparam int CFG_AW = 3;

  localparam logic [OCC_W-1:0] OCC_MAX     = 13'd8191;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 12'd175;

  // Register map
  localparam logic [CFG_AW-1:0] ADDR_BUFFER_LIMIT = 3'd0;

  // Event codes
  localparam logic CMD_LEN_CHANGE = 1'b0;
  localparam logic CMD_DROP       = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [PORT_W-1:0] port;
    logic [OCC_W-1:0]  old_len;
    logic [OCC_W-1:0]  new_len;
  } in_t;

  typedef struct packed {
    logic [OCC_W-1:0]  total_occupancy;
    logic              pushout;
    logic [PORT_W-1:0] pushout_port;
    logic [PORT_W-1:0] longest_port;
    logic [CNT_W-1:0]  port_passed;
    logic [CNT_W-1:0]  port_lost;
  } out_t;

  // One per-port entry of the state memory
  typedef struct packed {
    logic [OCC_W-1:0] occ;
    logic [CNT_W-1:0] passed;
    logic [CNT_W-1:0] lost;
  } ent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/psbm_cfg.sv =====
`default_nettype none

module psbm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psbm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [psbm_pkg::LIM_W-1:0]  buffer_limit_o
);
  import psbm_pkg::*;

  logic [LIM_W-1:0] limit_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_BUFFER_LIMIT);

  // Buffer limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (wr_en) begin
      limit_q <= pwdata[LIM_W-1:0];
    end
  end

  // Read back
  assign prdata = (paddr == ADDR_BUFFER_LIMIT) ? 32'(limit_q) : 32'd0;

  assign buffer_limit_o = limit_q;

endmodule

`default_nettype wire

// ===== rtl/pushout_shared_buffer_manager.sv =====
`default_nettype none
`include "assert_macros.svh"

// Shared-buffer pushout manager. Per-port occupancy, passed and lost counters
// live in one PORTS-deep synchronous memory with a registered read port, cleared
// at reset through per-entry valid bits. One transaction is handled at a time,
// and a finished result may wait in the output register while the next input
// transaction is taken. A drop report or a queue-length change reads the port
// entry, modifies it and writes it back; a queue-length change then walks all
// PORTS entries through the single memory read port, one per cycle, to rebuild
// the total and the sticky longest-queue index. When a queue-length change
// brings the total to buffer_limit + 1 the result orders one packet out of the
// longest queue and reports the total minus one. buffer_limit sits at byte
// address 0 of the APB port.
module pushout_shared_buffer_manager #(
  parameter int PORTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psbm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  psbm_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output psbm_pkg::out_t              out_data_o
);
  import psbm_pkg::*;

  localparam int AW = $clog2(PORTS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] NUM_PORTS = CW'(PORTS);
  localparam logic [AW-1:0] LAST_PORT = AW'(PORTS - 1);

  // Configuration
  logic [LIM_W-1:0] buffer_limit;

  psbm_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .buffer_limit_o (buffer_limit)
  );

  // Control and datapath registers
  state_e           state_q, state_d;
  in_t              cur_q, cur_d;
  logic             chg_q, chg_d;
  logic [CW-1:0]    iss_q, iss_d;
  logic [AW-1:0]    longest_q, longest_d;
  logic [OCC_W-1:0] lmax_q, lmax_d;
  logic [OCC_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] pp_q, pp_d;
  logic [CNT_W-1:0] pl_q, pl_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // Memory ports
  ent_t             mem_q [PORTS];
  logic [PORTS-1:0] valid_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  ent_t             rd_data_q;
  logic             rd_hit_q;
  logic             rd_pend_q;
  logic [AW-1:0]    rd_idx_q;
  ent_t             rd_ent;
  logic             wr_en;
  ent_t             upd;

  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    in_addr;
  logic             in_port_ok;
  logic [OCC_W-1:0] fall;
  logic [OCC_W-1:0] rise;
  logic [OCC_W:0]   occ_up;
  logic [OCC_W:0]   scan_sum;
  logic [OCC_W-1:0] scan_sat;
  logic [OCC_W-1:0] limit_p1;
  logic             push;

  assign cur_addr   = AW'(cur_q.port);
  assign in_addr    = AW'(in_data_i.port);
  assign in_port_ok = int'(in_data_i.port) < PORTS;

  // State memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cur_addr] <= upd;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Entry valid bits stand in for the reset clear of the memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_hit_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (wr_en) begin
        valid_q[cur_addr] <= 1'b1;
      end
      rd_pend_q <= rd_en;
      if (rd_en) begin
        rd_hit_q <= valid_q[rd_addr];
        rd_idx_q <= rd_addr;
      end
    end
  end

  assign rd_ent = rd_hit_q ? rd_data_q : '0;

  // Read-modify of the event port entry
  assign fall   = cur_q.old_len - cur_q.new_len;
  assign rise   = cur_q.new_len - cur_q.old_len;
  assign occ_up = {1'b0, rd_ent.occ} + {1'b0, rise};

  always_comb begin
    upd = rd_ent;
    if (cur_q.cmd == CMD_DROP) begin
      upd.lost = rd_ent.lost + 32'd1;
    end else if (cur_q.old_len > cur_q.new_len) begin
      upd.passed = rd_ent.passed + CNT_W'(fall);
      upd.occ    = (fall > rd_ent.occ) ? '0 : rd_ent.occ - fall;
    end else begin
      upd.occ = (occ_up > {1'b0, OCC_MAX}) ? OCC_MAX : occ_up[OCC_W-1:0];
    end
  end

  // Saturating running sum of the scan
  assign scan_sum = {1'b0, total_q} + {1'b0, rd_ent.occ};
  assign scan_sat = (scan_sum > {1'b0, OCC_MAX}) ? OCC_MAX : scan_sum[OCC_W-1:0];

  assign limit_p1 = {1'b0, buffer_limit} + 13'd1;
  assign push     = chg_q && (total_q == limit_p1);

  // Sequencer: next state, memory control and result build
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    chg_d       = chg_q;
    iss_d       = iss_q;
    longest_d   = longest_q;
    lmax_d      = lmax_q;
    total_d     = total_q;
    pp_d        = pp_q;
    pl_d        = pl_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = in_addr;
    wr_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cur_d = in_data_i;
          if (in_port_ok) begin
            rd_en   = 1'b1;
            state_d = ST_UPDATE;
          end else begin
            chg_d   = 1'b0;
            pp_d    = '0;
            pl_d    = '0;
            state_d = ST_FINISH;
          end
        end
      end
      ST_UPDATE: begin
        wr_en = 1'b1;
        pp_d  = upd.passed;
        pl_d  = upd.lost;
        if (cur_q.cmd == CMD_DROP) begin
          chg_d   = 1'b0;
          state_d = ST_FINISH;
        end else begin
          chg_d   = 1'b1;
          total_d = '0;
          iss_d   = '0;
          lmax_d  = (longest_q == cur_addr) ? upd.occ : lmax_q;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (iss_q < NUM_PORTS) begin
          rd_en   = 1'b1;
          rd_addr = iss_q[AW-1:0];
          iss_d   = iss_q + CW'(1);
        end
        if (rd_pend_q) begin
          total_d = scan_sat;
          if (rd_ent.occ > lmax_q) begin
            longest_d = rd_idx_q;
            lmax_d    = rd_ent.occ;
          end
          if (rd_idx_q == LAST_PORT) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.total_occupancy = push ? total_q - 13'd1 : total_q;
          out_d.pushout         = push;
          out_d.pushout_port    = push ? PORT_W'(longest_q) : '0;
          out_d.longest_port    = PORT_W'(longest_q);
          out_d.port_passed     = pp_q;
          out_d.port_lost       = pl_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      chg_q       <= 1'b0;
      iss_q       <= '0;
      longest_q   <= '0;
      lmax_q      <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      chg_q       <= chg_d;
      iss_q       <= iss_d;
      longest_q   <= longest_d;
      lmax_q      <= lmax_d;
      total_q     <= total_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pp_q  <= pp_d;
    pl_q  <= pl_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `PSBM_ASSERT(a_push_at_limit,
    out_valid_o && out_data_o.pushout |->
      out_data_o.total_occupancy == 13'(buffer_limit))
  `PSBM_ASSERT(a_push_port_longest,
    out_valid_o && out_data_o.pushout |->
      out_data_o.pushout_port == out_data_o.longest_port)
  `PSBM_ASSERT(a_change_scans,
    state_q == ST_UPDATE && cur_q.cmd == CMD_LEN_CHANGE |=> state_q == ST_SCAN)
  `PSBM_ASSERT_ALWAYS(a_write_in_update,
    wr_en |-> state_q == ST_UPDATE)

endmodule

`default_nettype wire

// ===== test/pushout_shared_buffer_manager_tb.sv =====
`timescale 1ns / 1ps

module pushout_shared_buffer_manager_tb;
  import psbm_pkg::*;

  localparam int          NPORTS      = 16;
  localparam int          PHASES      = 5;
  localparam int          PHASE_ITEMS = 220;
  localparam int          TAIL_CYCLES = 24;
  localparam int          HANG_LIMIT  = 2000;
  localparam [OCC_W-1:0]  LEN_MAX     = 13'd4096;

  // One directed row: event, whether the result is typed in, and that result
  typedef struct packed {
    in_t  ev;
    logic typed;
    out_t want;
  } dir_row_t;

  localparam out_t NO_WANT = '0;
  localparam int   DIR_N   = 19;

  // Directed traffic, applied right after reset with the reset buffer limit
  localparam dir_row_t DIRECTED [DIR_N] = '{
    // drop reports after reset, length fields ignored
    {CMD_DROP,       4'd0,  13'd0,    13'd0,    1'b1, 13'd0,    1'b0, 4'd0, 4'd0, 32'd0, 32'd1},
    {CMD_DROP,       4'd15, 13'd4096, 13'd4096, 1'b1, 13'd0,    1'b0, 4'd0, 4'd0, 32'd0, 32'd1},
    // largest single growth and fall
    {CMD_LEN_CHANGE, 4'd3,  13'd0,    13'd4096, 1'b1, 13'd4096, 1'b0, 4'd0, 4'd3, 32'd0, 32'd0},
    {CMD_LEN_CHANGE, 4'd3,  13'd4096, 13'd0,    1'b1, 13'd0,    1'b0, 4'd0, 4'd3, 32'd4096, 32'd0},
    // occupancy and total saturate at the top
    {CMD_LEN_CHANGE, 4'd5,  13'd0,    13'd4096, 1'b0, NO_WANT},
    {CMD_LEN_CHANGE, 4'd5,  13'd0,    13'd4096, 1'b1, 13'd8191, 1'b0, 4'd0, 4'd5, 32'd0, 32'd0},
    {CMD_LEN_CHANGE, 4'd7,  13'd0,    13'd4096, 1'b1, 13'd8191, 1'b0, 4'd0, 4'd5, 32'd0, 32'd0},
    // occupancy floors at zero, longest index leaves a shrinking queue, then stays on an empty one
    {CMD_LEN_CHANGE, 4'd5,  13'd4096, 13'd0,    1'b0, NO_WANT},
    {CMD_LEN_CHANGE, 4'd5,  13'd4096, 13'd0,    1'b0, NO_WANT},
    {CMD_LEN_CHANGE, 4'd7,  13'd4096, 13'd0,    1'b1, 13'd0,    1'b0, 4'd0, 4'd7, 32'd4096, 32'd0},
    {CMD_LEN_CHANGE, 4'd4,  13'd100,  13'd100,  1'b0, NO_WANT},
    // climb to limit + 1 and see the pushout from the longest queue
    {CMD_LEN_CHANGE, 4'd2,  13'd0,    13'd175,  1'b0, NO_WANT},
    {CMD_LEN_CHANGE, 4'd9,  13'd0,    13'd1,    1'b1, 13'd175,  1'b1, 4'd2, 4'd2, 32'd0, 32'd0},
    {CMD_LEN_CHANGE, 4'd2,  13'd175,  13'd174,  1'b0, NO_WANT},
    // equal length does not take the longest index
    {CMD_LEN_CHANGE, 4'd11, 13'd0,    13'd174,  1'b0, NO_WANT},
    {CMD_DROP,       4'd5,  13'd7,    13'd3,    1'b0, NO_WANT},
    {CMD_DROP,       4'd5,  13'd0,    13'd0,    1'b0, NO_WANT},
    {CMD_LEN_CHANGE, 4'd11, 13'd174,  13'd0,    1'b0, NO_WANT},
    {CMD_LEN_CHANGE, 4'd2,  13'd174,  13'd0,    1'b0, NO_WANT}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  // Mirror of the manager's state
  logic [OCC_W-1:0]    queue_occ   [NPORTS];
  logic [CNT_W-1:0]    passed_pkts [NPORTS];
  logic [CNT_W-1:0]    lost_pkts   [NPORTS];
  logic [PORT_W-1:0]   longest_q;
  logic [LIM_W-1:0]    buffer_limit_q;

  out_t                expected_reports [$];
  int unsigned         mismatches;
  int unsigned         hang_cycles = 0;
  int unsigned         stall_left  = 0;
  bit                  no_idle;
  bit                  pushout_owed;
  logic [PORT_W-1:0]   owed_port;

  pushout_shared_buffer_manager #(
    .PORTS(NPORTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned occ_total();
    int unsigned s;
    s = 0;
    foreach (queue_occ[i]) s += 32'(queue_occ[i]);
    return s;
  endfunction

  // Apply one event to the mirror and return the report it should produce
  function automatic out_t account_event(in_t ev);
    out_t        r;
    int unsigned fall;
    int unsigned grown;
    int unsigned sum;
    r = '0;
    if (ev.cmd == CMD_DROP) begin
      lost_pkts[ev.port] = lost_pkts[ev.port] + 1;
      sum = occ_total();
    end else begin
      if (ev.old_len > ev.new_len) begin
        fall = 32'(ev.old_len - ev.new_len);
        passed_pkts[ev.port] = passed_pkts[ev.port] + fall;
        queue_occ[ev.port] = (fall > 32'(queue_occ[ev.port])) ? '0 :
                             queue_occ[ev.port] - OCC_W'(fall);
      end else begin
        grown = 32'(queue_occ[ev.port]) + 32'(ev.new_len - ev.old_len);
        queue_occ[ev.port] = (grown > 32'(OCC_MAX)) ? OCC_MAX : OCC_W'(grown);
      end
      // rescan: total and sticky longest (strictly longer wins)
      sum = 0;
      for (int i = 0; i < NPORTS; i++) begin
        sum += 32'(queue_occ[i]);
        if (queue_occ[i] > queue_occ[longest_q]) longest_q = PORT_W'(i);
      end
      if (sum == 32'(buffer_limit_q) + 1) begin
        r.pushout      = 1'b1;
        r.pushout_port = longest_q;
        sum            = sum - 1;
      end
    end
    r.total_occupancy = (sum > 32'(OCC_MAX)) ? OCC_MAX : OCC_W'(sum);
    r.longest_port    = longest_q;
    r.port_passed     = passed_pkts[ev.port];
    r.port_lost       = lost_pkts[ev.port];
    return r;
  endfunction

  // Mostly well-formed traffic steering the total toward limit + 1,
  // plus drop reports and free-running length noise
  function automatic in_t next_traffic_event();
    in_t         ev;
    int unsigned sum;
    int unsigned target;
    int unsigned cap;
    int unsigned step;
    int unsigned roll;
    int unsigned p;
    ev     = '0;
    sum    = occ_total();
    target = 32'(buffer_limit_q) + 1;
    roll   = $urandom_range(0, 99);
    p      = $urandom_range(0, NPORTS - 1);
    ev.cmd = CMD_LEN_CHANGE;
    if (pushout_owed) begin
      // the ordered packet leaves its queue
      pushout_owed = 1'b0;
      ev.port      = owed_port;
      ev.old_len   = (queue_occ[owed_port] > LEN_MAX) ? LEN_MAX : queue_occ[owed_port];
      ev.new_len   = (ev.old_len == '0) ? '0 : ev.old_len - 13'd1;
    end else if (roll < 25) begin
      ev.cmd     = (roll < 10) ? CMD_DROP : CMD_LEN_CHANGE;
      ev.port    = PORT_W'(p);
      ev.old_len = ($urandom_range(0, 7) == 0) ? LEN_MAX :
                   OCC_W'($urandom_range(0, 32'(LEN_MAX)));
      ev.new_len = ($urandom_range(0, 7) == 0) ? LEN_MAX :
                   OCC_W'($urandom_range(0, 32'(LEN_MAX)));
    end else if (sum < target) begin
      cap = target - sum;
      if (cap > 512) cap = 512;
      step       = $urandom_range(1, cap);
      ev.port    = PORT_W'(p);
      ev.old_len = (32'(queue_occ[p]) + step > 32'(LEN_MAX)) ?
                   OCC_W'(32'(LEN_MAX) - step) : queue_occ[p];
      ev.new_len = OCC_W'(32'(ev.old_len) + step);
    end else begin
      // total at or above target means some queue is non-empty
      while (queue_occ[p] == '0) p = (p + 1) % NPORTS;
      cap = (queue_occ[p] > LEN_MAX) ? 32'(LEN_MAX) : 32'(queue_occ[p]);
      if (sum > target && sum - target < cap) cap = sum - target;
      step       = (sum > target) ? $urandom_range(1, cap) : 1;
      ev.port    = PORT_W'(p);
      ev.old_len = (queue_occ[p] > LEN_MAX) ? LEN_MAX : queue_occ[p];
      ev.new_len = OCC_W'(32'(ev.old_len) - step);
    end
    return ev;
  endfunction

  task automatic report_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Send one event; a typed row overrides the predicted report
  task automatic send_event(in_t ev, logic typed, out_t want);
    int unsigned gap;
    out_t        predicted;
    gap = (!no_idle && $urandom_range(0, 99) < 23) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = account_event(ev);
    if (predicted.pushout) begin
      pushout_owed = 1'b1;
      owed_port    = predicted.pushout_port;
    end
    expected_reports.push_back(typed ? want : predicted);
  endtask

  // Hold off the sender until every report is back, then let the block settle
  task automatic wait_for_reports(int unsigned tail);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic verify_limit_reg(logic [LIM_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_BUFFER_LIMIT;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    report_field("buffer_limit readback", {20'd0, want}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the limit with junk in the unused upper bits
  task automatic program_limit(logic [LIM_W-1:0] lim);
    logic [19:0] junk;
    junk    = 20'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BUFFER_LIMIT;
    pwdata  <= {junk, lim};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    buffer_limit_q = lim;
    @(posedge clk_i);
    verify_limit_reg(lim);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data_o);
      end else begin
        out_t want;
        want = expected_reports.pop_front();
        report_field("total_occupancy", want.total_occupancy, out_data_o.total_occupancy);
        report_field("pushout", want.pushout, out_data_o.pushout);
        report_field("pushout_port", want.pushout_port, out_data_o.pushout_port);
        report_field("longest_port", want.longest_port, out_data_o.longest_port);
        report_field("port_passed", want.port_passed, out_data_o.port_passed);
        report_field("port_lost", want.port_lost, out_data_o.port_lost);
      end
    end
  end

  // Receiver back-pressure: short random stalls, rare long ones, none while no_idle is set
  always @(posedge clk_i) begin
    if (no_idle) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 299) == 0) begin
      stall_left  <= $urandom_range(10, 40);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 23);
    end
  end

  // Hang detection: too long without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    logic [LIM_W-1:0] phase_limit [PHASES];
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    mismatches   = 0;
    no_idle      = 1'b0;
    pushout_owed = 1'b0;
    owed_port    = '0;
    foreach (queue_occ[i]) begin
      queue_occ[i]   = '0;
      passed_pkts[i] = '0;
      lost_pkts[i]   = '0;
    end
    longest_q      = '0;
    buffer_limit_q = LIMIT_RESET;

    // extremes first, then a mid value without idling, then random and reset value
    phase_limit[0] = 12'd1;
    phase_limit[1] = 12'd4095;
    phase_limit[2] = 12'd30;
    phase_limit[3] = LIM_W'($urandom_range(2, 4094));
    phase_limit[4] = LIMIT_RESET;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    verify_limit_reg(LIMIT_RESET);

    for (int r = 0; r < DIR_N; r++)
      send_event(DIRECTED[r].ev, DIRECTED[r].typed, DIRECTED[r].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_reports(TAIL_CYCLES);
      program_limit(phase_limit[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender stops until the pipeline has fully drained
        if (n == PHASE_ITEMS / 2 && (ph == 0 || ph == 3)) wait_for_reports(0);
        send_event(next_traffic_event(), 1'b0, NO_WANT);
      end
    end
    no_idle = 1'b0;

    wait_for_reports(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
